@@ hw/rtl/gobn_pkg.sv @@
// ----------------------------------------------------------------------------
// gobn_pkg
// Shared types and constants of the go-back-N sender: controller states,
// burst kinds and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gobn_pkg;

    localparam int unsigned FRAME_W = 16;
    localparam int unsigned NEXT_W  = FRAME_W + 1;

    // Input word kinds carried on tuser
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_ACK   = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_COUNT,
        S_SEND
    } t_state;

    typedef enum logic [1:0] {
        BURST_NONE,
        BURST_ONE,
        BURST_WINDOW
    } t_burst;

    typedef struct packed {
        logic accept;   // latch the input word
        logic eval;     // update transfer state from the latched word
        logic count;    // size the burst of frames to send
        logic emit;     // load one result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;   // output register can take a word this cycle
        logic emit_last;  // the next emitted word is the final one
    } t_dp_sts;

endpackage

@@ hw/rtl/go_back_n_sender_unit.sv @@
// ----------------------------------------------------------------------------
// go_back_n_sender_unit
// Sender side of a go-back-N sliding-window ARQ with a sequencer/datapath
// split.
// ----------------------------------------------------------------------------
// Usage:
//   Write the frame count through i_cfg_we/i_cfg_data while the unit is idle.
//   Input words on the s_axis side: tuser selects start (0) or ack (1),
//   tdata carries the acked frame number. Each input word yields one to
//   WINDOW result words on the m_axis side; tlast marks the final one.
//   A word that sends no frame yields one word with sent cleared.
// Sequence and throughput:
//   An input word is accepted, then the transfer state is updated and the
//   burst sized (1 to WINDOW result words), then one result word per cycle
//   is loaded into the output register while that register can take a word.
//   s_axis_tready is high only while the sequencer is idle.
// Reset:
//   i_rst_n (synchronous, active low) clears the frame count and the
//   transfer state (next frame 1, nothing acked, not recovering, not done).
// Stall:
//   When m_axis_tready is low the output register holds its word and the
//   burst pauses; a new input word is still taken after the last result
//   has been loaded.
// ----------------------------------------------------------------------------
module go_back_n_sender_unit
    import gobn_pkg::*;
#(
    parameter int unsigned WINDOW = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: frame count
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] ack_number
    input  logic        s_axis_tuser,   // [0] func
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] frame_number
    output logic [2:0]  m_axis_tuser,   // [0] sent, [1] discarded, [2] done_res
    output logic        m_axis_tlast    // last
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    sent;
    logic    discarded;
    logic    done_res;

    gobn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gobn_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_func         (s_axis_tuser),
        .i_ack_number   (s_axis_tdata),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_sent         (sent),
        .o_frame_number (m_axis_tdata),
        .o_discarded    (discarded),
        .o_done_res     (done_res),
        .o_last         (m_axis_tlast)
    );

    // Pack result flags
    assign m_axis_tuser = {done_res, discarded, sent};

endmodule

@@ hw/rtl/gobn_ctrl.sv @@
// ----------------------------------------------------------------------------
// gobn_ctrl
// Sequencer of the go-back-N sender: accepts one word, steps the datapath
// through evaluation and burst sizing, then paces the result words.
// ----------------------------------------------------------------------------
module gobn_ctrl
    import gobn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_COUNT;
            end
            S_COUNT: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_sts.out_free && i_sts.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
            end
            S_COUNT: begin
                o_cmd.count = 1'b1;
            end
            S_SEND: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ hw/rtl/gobn_dp.sv @@
// ----------------------------------------------------------------------------
// gobn_dp
// Datapath of the go-back-N sender: transfer state, burst counter and the
// output register that decouples the result stream from the sequencer.
// ----------------------------------------------------------------------------
module gobn_dp
    import gobn_pkg::*;
#(
    parameter int unsigned WINDOW = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [FRAME_W-1:0] i_cfg_data,
    input  logic               i_func,
    input  logic [FRAME_W-1:0] i_ack_number,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_sent,
    output logic [FRAME_W-1:0] o_frame_number,
    output logic               o_discarded,
    output logic               o_done_res,
    output logic               o_last
);

    localparam int unsigned CW = $clog2(WINDOW + 1);
    localparam logic [CW-1:0] WIN_CNT = CW'(WINDOW);

    logic [FRAME_W-1:0] r_frame_count;
    logic               r_func;
    logic [FRAME_W-1:0] r_ack;
    logic [NEXT_W-1:0]  r_next_frame;
    logic [FRAME_W-1:0] r_last_acked;
    logic               r_recovering;
    logic [FRAME_W-1:0] r_recovery_target;
    logic               r_finished;
    t_burst             r_burst;
    logic               r_disc;
    logic [CW-1:0]      r_remain;
    logic               r_out_valid;
    logic               r_out_sent;
    logic [FRAME_W-1:0] r_out_frame;
    logic               r_out_disc;
    logic               r_out_done;
    logic               r_out_last;

    logic [NEXT_W-1:0]  la_inc;
    logic [NEXT_W-1:0]  avail;
    logic [CW-1:0]      limit;
    logic               out_free;

    assign la_inc   = {1'b0, r_last_acked} + NEXT_W'(1);
    assign out_free = !r_out_valid || i_out_ready;

    // Frames still allowed by the frame count from next_frame on, and the burst limit
    always_comb begin
        if (r_next_frame <= {1'b0, r_frame_count}) begin
            avail = {1'b0, r_frame_count} - r_next_frame + NEXT_W'(1);
        end else begin
            avail = '0;
        end
        case (r_burst)
            BURST_ONE:    limit = CW'(1);
            BURST_WINDOW: limit = WIN_CNT;
            default:      limit = '0;
        endcase
    end

    assign o_sts.out_free  = out_free;
    assign o_sts.emit_last = (r_remain <= CW'(1));

    // Frame count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
        end else if (i_cfg_we) begin
            r_frame_count <= i_cfg_data;
        end
    end

    // Latch the input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= i_func;
            r_ack  <= i_ack_number;
        end
    end

    // Transfer state, burst sizing and frame advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_frame      <= NEXT_W'(1);
            r_last_acked      <= '0;
            r_recovering      <= 1'b0;
            r_recovery_target <= '0;
            r_finished        <= 1'b0;
            r_burst           <= BURST_NONE;
            r_disc            <= 1'b0;
            r_remain          <= '0;
        end else begin
            if (i_cmd.eval) begin
                r_disc  <= 1'b0;
                r_burst <= BURST_NONE;
                if (r_func == FUNC_START) begin
                    r_next_frame      <= NEXT_W'(1);
                    r_last_acked      <= '0;
                    r_recovering      <= 1'b0;
                    r_recovery_target <= '0;
                    r_finished        <= (r_frame_count == '0);
                    r_burst           <= BURST_WINDOW;
                end else if (r_finished) begin
                    r_burst <= BURST_NONE;
                end else if (r_recovering) begin
                    // wait for the ack of the retransmitted frame
                    if (r_ack == r_recovery_target) begin
                        r_last_acked <= r_recovery_target;
                        r_recovering <= 1'b0;
                        if (r_recovery_target >= r_frame_count) begin
                            r_finished <= 1'b1;
                        end
                        r_burst <= BURST_WINDOW;
                    end else begin
                        r_disc <= 1'b1;
                    end
                end else if ({1'b0, r_ack} == la_inc) begin
                    r_last_acked <= r_ack;
                    if (r_ack >= r_frame_count) begin
                        r_finished <= 1'b1;
                    end
                    r_burst <= BURST_ONE;
                end else begin
                    // go back to the frame after the last acked one
                    r_next_frame <= la_inc;
                    r_recovering <= 1'b1;
                    r_burst      <= BURST_ONE;
                    if (la_inc <= {1'b0, r_frame_count}) begin
                        r_recovery_target <= la_inc[FRAME_W-1:0];
                    end else begin
                        r_recovery_target <= r_last_acked;
                    end
                end
            end
            if (i_cmd.count) begin
                if (avail < NEXT_W'(limit)) begin
                    r_remain <= avail[CW-1:0];
                end else begin
                    r_remain <= limit;
                end
            end
            if (i_cmd.emit && (r_remain != '0)) begin
                r_next_frame <= r_next_frame + NEXT_W'(1);
                r_remain     <= r_remain - CW'(1);
            end
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_done <= r_finished;
            r_out_last <= (r_remain <= CW'(1));
            if (r_remain != '0) begin
                r_out_sent  <= 1'b1;
                r_out_frame <= r_next_frame[FRAME_W-1:0];
                r_out_disc  <= 1'b0;
            end else begin
                r_out_sent  <= 1'b0;
                r_out_frame <= '0;
                r_out_disc  <= r_disc;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sent         = r_out_sent;
    assign o_frame_number = r_out_frame;
    assign o_discarded    = r_out_disc;
    assign o_done_res     = r_out_done;
    assign o_last         = r_out_last;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the go-back-N sender. A clocked driver feeds start
// and ack words from a queue, a clocked monitor checks every result word
// against a cycle-free model of the sender, and both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import gobn_pkg::*;

    localparam int unsigned WINDOW       = 5;
    localparam int unsigned BURST_MAX    = (WINDOW < 8) ? WINDOW : 8;
    localparam int unsigned SETTLE       = WINDOW + 8;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef struct {
        logic        func;
        logic [15:0] ack;
    } t_ack_word;

    typedef struct {
        logic        sent;
        logic [15:0] frame;
        logic        discarded;
        logic        done;
        logic        last;
    } t_result_word;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [15:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    go_back_n_sender_unit #(
        .WINDOW(WINDOW)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    t_ack_word    pending_words[$];
    t_result_word expected_words[$];
    logic [15:0]  burst_frames[$];
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count    = 0;
    logic         no_idle        = 1'b0;

    // Sender model state
    logic [15:0] frame_total = '0;
    logic [16:0] tx_next     = 17'd1;
    logic [15:0] tx_acked    = '0;
    logic        tx_waiting  = 1'b0;
    logic [15:0] tx_target   = '0;
    logic        tx_done     = 1'b0;

    // Stimulus-side guess of where the transfer stands
    logic [15:0] g_acked  = '0;
    logic [15:0] g_target = '0;
    logic        g_wait   = 1'b0;
    logic        g_done   = 1'b0;

    // Mostly short gaps, a few long ones; none while no_idle is set
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Queue up to count frames, never past the frame total
    task automatic push_frames(input int unsigned count);
        for (int unsigned i = 0; i < count && tx_next <= {1'b0, frame_total}; i++) begin
            burst_frames.push_back(tx_next[15:0]);
            tx_next = tx_next + 17'd1;
        end
    endtask

    // Advance the sender model by one word and queue the result words it causes
    task automatic predict_frame_burst(input logic func, input logic [15:0] ack);
        logic         dropped;
        t_result_word w;
        dropped = 1'b0;
        burst_frames.delete();
        if (func == FUNC_START) begin
            tx_next    = 17'd1;
            tx_acked   = '0;
            tx_waiting = 1'b0;
            tx_target  = '0;
            tx_done    = (frame_total == 16'd0);
            push_frames(BURST_MAX);
        end else if (tx_done) begin
            // transfer complete: ack ignored
        end else if (tx_waiting) begin
            if (ack == tx_target) begin
                tx_acked   = tx_target;
                tx_waiting = 1'b0;
                if (tx_acked >= frame_total)
                    tx_done = 1'b1;
                push_frames(BURST_MAX);
            end else begin
                dropped = 1'b1;
            end
        end else if ({1'b0, ack} == {1'b0, tx_acked} + 17'd1) begin
            tx_acked = ack;
            if (tx_acked >= frame_total)
                tx_done = 1'b1;
            push_frames(1);
        end else begin
            // go back: resend the frame after the last acked one and wait for it
            tx_next = {1'b0, tx_acked} + 17'd1;
            push_frames(1);
            tx_target  = tx_next[15:0] - 16'd1;
            tx_waiting = 1'b1;
        end

        if (burst_frames.size() == 0) begin
            w.sent      = 1'b0;
            w.frame     = '0;
            w.discarded = dropped;
            w.done      = tx_done;
            w.last      = 1'b1;
            expected_words.push_back(w);
        end else begin
            foreach (burst_frames[i]) begin
                w.sent      = 1'b1;
                w.frame     = burst_frames[i];
                w.discarded = 1'b0;
                w.done      = tx_done;
                w.last      = (i == burst_frames.size() - 1);
                expected_words.push_back(w);
            end
        end
    endtask

    // Driver: hold the word until accepted, then insert a gap and present the next
    t_ack_word   drv_word = '{func: 1'b0, ack: 16'd0};
    int unsigned drv_gap  = 0;

    always @(posedge i_clk) begin
        logic holding;
        logic nxt_valid;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            drv_gap = 0;
        end else begin
            holding = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_frame_burst(drv_word.func, drv_word.ack);
                holding = 1'b0;
            end
            nxt_valid = holding;
            if (!holding) begin
                if (drv_gap > 0) begin
                    drv_gap = drv_gap - 1;
                end else if (pending_words.size() != 0) begin
                    drv_word  = pending_words.pop_front();
                    nxt_valid = 1'b1;
                    drv_gap   = pick_gap();
                end
            end
            s_axis_tvalid <= nxt_valid;
            s_axis_tdata  <= drv_word.ack;
            s_axis_tuser  <= drv_word.func;
        end
    end

    // Monitor: check each accepted result word, stall at random
    int unsigned mon_stall = 0;

    always @(posedge i_clk) begin
        t_result_word exp_w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            mon_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_words.size() == 0) begin
                    mismatch_count++;
                    $display("%0t unexpected word: expected none, actual %0h %0h %0b",
                             $realtime, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end else begin
                    exp_w = expected_words.pop_front();
                    if (m_axis_tuser[0] !== exp_w.sent) begin
                        mismatch_count++;
                        $display("%0t sent: expected %0b, actual %0b",
                                 $realtime, exp_w.sent, m_axis_tuser[0]);
                    end
                    if (m_axis_tdata !== exp_w.frame) begin
                        mismatch_count++;
                        $display("%0t frame_number: expected %0d, actual %0d",
                                 $realtime, exp_w.frame, m_axis_tdata);
                    end
                    if (m_axis_tuser[1] !== exp_w.discarded) begin
                        mismatch_count++;
                        $display("%0t discarded: expected %0b, actual %0b",
                                 $realtime, exp_w.discarded, m_axis_tuser[1]);
                    end
                    if (m_axis_tuser[2] !== exp_w.done) begin
                        mismatch_count++;
                        $display("%0t done_res: expected %0b, actual %0b",
                                 $realtime, exp_w.done, m_axis_tuser[2]);
                    end
                    if (m_axis_tlast !== exp_w.last) begin
                        mismatch_count++;
                        $display("%0t last: expected %0b, actual %0b",
                                 $realtime, exp_w.last, m_axis_tlast);
                    end
                end
            end
            if (mon_stall > 0) begin
                mon_stall = mon_stall - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                mon_stall = pick_gap();
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic queue_word(input logic func, input logic [15:0] ack);
        t_ack_word w;
        w.func = func;
        w.ack  = ack;
        pending_words.push_back(w);
    endtask

    // Wait until every word is taken and every result has come out
    task automatic drain();
        while (pending_words.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_frame_total(input logic [15:0] value);
        drain();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        frame_total = value;
        @(negedge i_clk);
    endtask

    // Mostly well-formed transfers with random content, plus noise acks
    task automatic queue_random_run(input int unsigned n_items);
        int unsigned r;
        logic [15:0] a;
        for (int unsigned k = 0; k < n_items; k++) begin
            r = $urandom_range(0, 99);
            if (r < 5 || (g_done && r < 60)) begin
                queue_word(FUNC_START, 16'($urandom));
                g_acked = '0;
                g_wait  = 1'b0;
                g_done  = (frame_total == 16'd0);
            end else if (g_wait) begin
                if (r < 70) begin
                    queue_word(FUNC_ACK, g_target);
                    g_acked = g_target;
                    g_wait  = 1'b0;
                    g_done  = (g_acked >= frame_total);
                end else begin
                    queue_word(FUNC_ACK, 16'($urandom));
                end
            end else if (r < 80) begin
                a = g_acked + 16'd1;
                queue_word(FUNC_ACK, a);
                g_acked = a;
                g_done  = (a >= frame_total);
            end else begin
                // out of order: a near miss, a duplicate, or a wild value
                if (r < 86)
                    a = g_acked + 16'($urandom_range(2, 4));
                else if (r < 92)
                    a = g_acked;
                else
                    a = 16'($urandom);
                queue_word(FUNC_ACK, a);
                if (a == g_acked + 16'd1) begin
                    g_acked = a;
                    g_done  = (a >= frame_total);
                end else begin
                    g_wait   = 1'b1;
                    g_target = (g_acked + 16'd1 <= frame_total) ? g_acked + 16'd1 : g_acked;
                end
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Acks against the reset state, then an empty transfer and an ack after it
        queue_word(FUNC_ACK, 16'd0);
        queue_word(FUNC_ACK, 16'd5);
        queue_word(FUNC_ACK, 16'd0);
        queue_word(FUNC_START, 16'hFFFF);
        queue_word(FUNC_ACK, 16'd3);

        // Full window, in-order acks, go back, discards, recovery
        write_frame_total(16'd12);
        queue_word(FUNC_START, 16'd0);
        queue_word(FUNC_ACK, 16'd1);
        queue_word(FUNC_ACK, 16'd2);
        queue_word(FUNC_ACK, 16'd4);
        queue_word(FUNC_ACK, 16'd5);
        queue_word(FUNC_ACK, 16'hFFFF);
        queue_word(FUNC_ACK, 16'd3);
        queue_word(FUNC_ACK, 16'd4);
        queue_word(FUNC_ACK, 16'd6);
        queue_word(FUNC_ACK, 16'd5);

        // Lower the frame count mid-transfer so nothing is left to resend
        write_frame_total(16'd8);
        queue_word(FUNC_START, 16'h8000);
        queue_word(FUNC_ACK, 16'd1);
        queue_word(FUNC_ACK, 16'd2);
        write_frame_total(16'd2);
        queue_word(FUNC_ACK, 16'd5);
        queue_word(FUNC_ACK, 16'd1);
        queue_word(FUNC_ACK, 16'd2);
        queue_word(FUNC_ACK, 16'hFFFF);

        // Random transfers over a spread of frame counts
        write_frame_total(16'd1);
        queue_random_run(25);
        write_frame_total(16'hFFFF);
        no_idle = 1'b1;
        queue_random_run(25);
        write_frame_total(16'd0);
        no_idle = 1'b0;
        queue_random_run(25);
        write_frame_total(16'd5);
        queue_random_run(25);
        write_frame_total(16'd6);
        no_idle = 1'b1;
        queue_random_run(25);
        write_frame_total(16'd3);
        no_idle = 1'b0;
        queue_random_run(25);
        write_frame_total(16'd40);
        queue_random_run(25);
        write_frame_total(16'($urandom_range(2, 30)));
        queue_random_run(25);

        drain();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/gobn_pkg.sv
hw/rtl/gobn_ctrl.sv
hw/rtl/gobn_dp.sv
hw/rtl/go_back_n_sender_unit.sv
sim/testbench.sv
